@@ hdl/u8map_pkg.sv @@
// ---------------------------------------------------------------------------
// u8map_pkg
// Shared types and constants of the UTF-8 to code table mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package u8map_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 16;
	localparam int CODE_W      = 8;
	localparam int ENTRY_W     = KEY_W + CODE_W;
	localparam int POINT_W     = 21;

	// request function codes
	typedef enum logic [1:0] {
		FN_TEXT  = 2'd0,
		FN_ADD   = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	// result status codes
	typedef enum logic [2:0] {
		RS_MAPPED   = 3'd0,
		RS_UNMAPPED = 3'd1,
		RS_ADDED    = 3'd2,
		RS_FULL     = 3'd3,
		RS_CLEARED  = 3'd4
	} res_status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_act;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_res;
		logic item_scan;
		logic scan_done;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/u8map_ram.sv @@
// ---------------------------------------------------------------------------
// u8map_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module u8map_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                         wr_data,
	input  wire logic                                     rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/u8map_dp.sv @@
// ---------------------------------------------------------------------------
// u8map_dp
// Datapath: UTF-8 byte decoder, table memory, linear lookup scan and
// result / output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module u8map_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire u8map_pkg::cmd_t             cmd,
	output u8map_pkg::sts_t                  sts,
	input  wire logic [1:0]                  func,
	input  wire logic [u8map_pkg::KEY_W-1:0] entry_unicode,
	input  wire logic [u8map_pkg::CODE_W-1:0] entry_code,
	input  wire logic [7:0]                  text_byte,
	input  wire logic                        text_end,
	output logic      [2:0]                  status,
	output logic      [u8map_pkg::CODE_W-1:0] char_code,
	output logic      [2:0]                  bytes_used
);

	// decoder state
	logic [u8map_pkg::POINT_W-1:0] acc_q, acc_d;
	logic [1:0]                    pend_q, pend_d;
	logic [2:0]                    seen_q, seen_d;
	logic [u8map_pkg::CNT_W-1:0]   cnt_q;

	// scan state
	logic [u8map_pkg::CNT_W-1:0]   scan_idx_q;
	logic                          rd_pend_q;
	logic [u8map_pkg::KEY_W-1:0]   point_q;

	// pending result and output registers
	u8map_pkg::res_status_t        res_status_q;
	logic [u8map_pkg::CODE_W-1:0]  res_code_q;
	logic [2:0]                    res_used_q;
	logic [2:0]                    status_q;
	logic [u8map_pkg::CODE_W-1:0]  char_code_q;
	logic [2:0]                    bytes_used_q;

	// decode of the offered request
	logic                          d_res, d_lookup, d_scan, d_elig;
	logic [2:0]                    d_used;
	logic [u8map_pkg::POINT_W-1:0] d_point, acc_next;
	logic [1:0]                    pend_dec;
	logic [2:0]                    used_inc;
	logic                          is_add, is_clear, is_text, full;

	// memory
	logic                           wr_en, rd_en, hit, exhausted;
	logic [u8map_pkg::ENTRY_W-1:0]  rd_data;

	assign is_text  = (u8map_pkg::func_t'(func) == u8map_pkg::FN_TEXT);
	assign is_add   = (u8map_pkg::func_t'(func) == u8map_pkg::FN_ADD);
	assign is_clear = (u8map_pkg::func_t'(func) == u8map_pkg::FN_CLEAR);
	assign full     = (cnt_q >= u8map_pkg::CNT_W'(u8map_pkg::TABLE_DEPTH));

	assign used_inc = seen_q + 3'd1;
	assign acc_next = {acc_q[u8map_pkg::POINT_W-7:0], text_byte[5:0]};
	assign pend_dec = pend_q - 2'd1;

	always_comb begin
		pend_d   = pend_q;
		seen_d   = seen_q;
		acc_d    = acc_q;
		d_res    = 1'b0;
		d_lookup = 1'b0;
		d_used   = used_inc;
		d_point  = acc_next;
		if (!text_byte[7]) begin
			d_res   = 1'b1;
			d_point = {13'd0, text_byte};
			if (pend_q == 2'd0) begin
				d_lookup = 1'b1;
				d_used   = 3'd1;
			end
		end else if (text_byte[6] == 1'b0) begin
			// continuation byte
			if (pend_q == 2'd0) begin
				d_res  = 1'b1;
				d_used = 3'd1;
			end else if (pend_dec == 2'd0) begin
				d_res    = 1'b1;
				d_lookup = 1'b1;
			end else if (text_end) begin
				d_res = 1'b1;
			end else begin
				acc_d  = acc_next;
				pend_d = pend_dec;
				seen_d = used_inc;
			end
		end else if (pend_q != 2'd0) begin
			d_res = 1'b1;
		end else begin
			d_used = 3'd1;
			if (text_byte[7:3] == 5'b11110) begin
				pend_d = 2'd3;
				acc_d  = {18'd0, text_byte[2:0]};
			end else if (text_byte[7:4] == 4'b1110) begin
				pend_d = 2'd2;
				acc_d  = {17'd0, text_byte[3:0]};
			end else if (text_byte[7:5] == 3'b110) begin
				pend_d = 2'd1;
				acc_d  = {16'd0, text_byte[4:0]};
			end else begin
				d_res = 1'b1;
			end
			seen_d = 3'd1;
			if (text_end) begin
				d_res = 1'b1;
			end
		end
		// every result returns the decoder to idle
		if (d_res) begin
			pend_d = 2'd0;
			seen_d = 3'd0;
			acc_d  = '0;
		end
	end

	assign d_elig = (d_point != '0) && (d_point[u8map_pkg::POINT_W-1:u8map_pkg::KEY_W] == '0);
	assign d_scan = is_text && d_lookup && d_elig && (cnt_q != '0);

	assign sts.item_res  = is_text ? d_res : (is_add || is_clear);
	assign sts.item_scan = d_scan;

	// scan: one read issued per cycle, compare in the cycle after the read
	assign hit       = rd_pend_q && (rd_data[u8map_pkg::ENTRY_W-1:u8map_pkg::CODE_W] == point_q);
	assign exhausted = !rd_pend_q && (scan_idx_q == cnt_q);
	assign sts.scan_done = hit || exhausted;
	assign rd_en = cmd.scan_act && !hit && (scan_idx_q < cnt_q);
	assign wr_en = cmd.accept && is_add && !full;

	u8map_ram #(
		.WIDTH (u8map_pkg::ENTRY_W),
		.DEPTH (u8map_pkg::TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[u8map_pkg::IDX_W-1:0]),
		.wr_data ({entry_unicode, entry_code}),
		.rd_en   (rd_en),
		.rd_addr (scan_idx_q[u8map_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			pend_q     <= 2'd0;
			seen_q     <= 3'd0;
			cnt_q      <= '0;
			scan_idx_q <= '0;
			rd_pend_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				scan_idx_q <= '0;
				rd_pend_q  <= 1'b0;
				if (is_text) begin
					acc_q  <= acc_d;
					pend_q <= pend_d;
					seen_q <= seen_d;
				end else if (is_add && !full) begin
					cnt_q <= cnt_q + u8map_pkg::CNT_W'(1);
				end else if (is_clear) begin
					cnt_q <= '0;
				end
			end else if (cmd.scan_act) begin
				rd_pend_q <= rd_en;
				if (rd_en) begin
					scan_idx_q <= scan_idx_q + u8map_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			point_q    <= d_point[u8map_pkg::KEY_W-1:0];
			res_code_q <= '0;
			if (is_text) begin
				res_status_q <= u8map_pkg::RS_UNMAPPED;
				res_used_q   <= d_used;
			end else begin
				res_used_q   <= 3'd0;
				if (is_add) begin
					res_status_q <= full ? u8map_pkg::RS_FULL : u8map_pkg::RS_ADDED;
				end else begin
					res_status_q <= u8map_pkg::RS_CLEARED;
				end
			end
		end else if (cmd.scan_act && hit) begin
			res_status_q <= u8map_pkg::RS_MAPPED;
			res_code_q   <= rd_data[u8map_pkg::CODE_W-1:0];
		end
		if (cmd.out_load) begin
			status_q     <= res_status_q;
			char_code_q  <= res_code_q;
			bytes_used_q <= res_used_q;
		end
	end

	assign status     = status_q;
	assign char_code  = char_code_q;
	assign bytes_used = bytes_used_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= u8map_pkg::CNT_W'(u8map_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_seq_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != 2'd0) |-> (({1'b0, seen_q} + {2'b00, pend_q}) <= 4'd4 && seen_q != 3'd0))
		else $error("decoder sequence length inconsistent");

	a_rd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (scan_idx_q != '0))
		else $error("compare pending without an issued read");

endmodule

`default_nettype wire

@@ hdl/u8map_ctrl.sv @@
// ---------------------------------------------------------------------------
// u8map_ctrl
// Controller: request acceptance, lookup scan sequencing, output handoff.
// ---------------------------------------------------------------------------
`default_nettype none

module u8map_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output u8map_pkg::cmd_t      cmd,
	input  wire u8map_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	state_t st_q, st_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st_d         = st_q;
		cmd.accept   = in_valid && (st_q == ST_IDLE);
		cmd.scan_act = (st_q == ST_SCAN);
		cmd.out_load = (st_q == ST_PUSH) && out_free;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					if (sts.item_scan) begin
						st_d = ST_SCAN;
					end else if (sts.item_res) begin
						st_d = ST_PUSH;
					end
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					st_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/utf8_to_code_table_mapper.sv @@
// ---------------------------------------------------------------------------
// utf8_to_code_table_mapper
// Decodes UTF-8 text bytes and maps each completed code point to an 8-bit
// target code through a table of up to TABLE_DEPTH entries.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | func, entry_unicode, entry_code,
//          |           |                    | text_byte, text_end
//  out     | output    | out_valid/out_stall| status, char_code, bytes_used
//
// A request that yields no result (a byte inside a sequence) leaves the block idle.
// Add, clear, rejected bytes and code points that cannot hit skip the scan.
// A lookup scans the table memory from index 0 upward, one read per cycle,
// and stops at the first hit, or after the last live entry on a miss; the
// table memory has a single read port, so entries are read one at a time.
// Reset clears the entry count and the decoder; table contents need no clear.
// A finished result waits in the output register while the next request is
// taken; a stalled output holds only the block's final handoff step.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_to_code_table_mapper (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   func,
	input  wire logic [u8map_pkg::KEY_W-1:0]  entry_unicode,
	input  wire logic [u8map_pkg::CODE_W-1:0] entry_code,
	input  wire logic [7:0]                   text_byte,
	input  wire logic                         text_end,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [2:0]                   status,
	output logic      [u8map_pkg::CODE_W-1:0] char_code,
	output logic      [2:0]                   bytes_used
);

	// controller commands and datapath status
	u8map_pkg::cmd_t cmd;
	u8map_pkg::sts_t sts;

	// sequence: accept, scan the table, hand the result to the output register
	u8map_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// decode bytes, hold the table, compare entries, drive the result payload
	u8map_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.entry_unicode (entry_unicode),
		.entry_code    (entry_code),
		.text_byte     (text_byte),
		.text_end      (text_end),
		.status        (status),
		.char_code     (char_code),
		.bytes_used    (bytes_used)
	);

endmodule

`default_nettype wire

@@ tb/code_map_sb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// code_map_sb_pkg
// Scoreboard for the UTF-8 to code table mapper. It keeps its own copy of the
// table and the byte decoder, predicts the result of every accepted request
// and checks results in arrival order, field by field.
// ---------------------------------------------------------------------------
package code_map_sb_pkg;

	import u8map_pkg::*;

	typedef struct {
		res_status_t      st;
		bit [CODE_W-1:0]  char_code;
		bit [2:0]         used;
	} char_result_t;

	class code_map_scoreboard;
		bit [KEY_W-1:0]   keys  [TABLE_DEPTH];
		bit [CODE_W-1:0]  codes [TABLE_DEPTH];
		int unsigned      fill;
		bit [POINT_W-1:0] point;
		bit [1:0]         due;
		bit [2:0]         seen;
		char_result_t     owed_results[$];
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      by_status[5];

		function new();
			fill    = 0;
			point   = '0;
			due     = '0;
			seen    = '0;
			errors  = 0;
			checked = 0;
			foreach (by_status[i]) by_status[i] = 0;
		endfunction

		function int unsigned outstanding();
			return owed_results.size();
		endfunction

		function void owe(res_status_t st, bit [CODE_W-1:0] cc, bit [2:0] used);
			char_result_t r;
			r.st        = st;
			r.char_code = cc;
			r.used      = used;
			owed_results.push_back(r);
		endfunction

		// drop the partial character and report it as unmapped
		function void reject_seq(bit [2:0] used);
			point = '0;
			due   = '0;
			seen  = '0;
			owe(RS_UNMAPPED, '0, used);
		endfunction

		// search live entries from index 0 up; first hit wins
		function void finish_char(bit [POINT_W-1:0] cp, bit [2:0] used);
			point = '0;
			due   = '0;
			seen  = '0;
			if (cp != 0 && cp <= 21'h00FFFF) begin
				for (int i = 0; i < fill; i++) begin
					if (keys[i] == cp[KEY_W-1:0]) begin
						owe(RS_MAPPED, codes[i], used);
						return;
					end
				end
			end
			owe(RS_UNMAPPED, '0, used);
		endfunction

		function void start_seq(bit [1:0] n, bit [POINT_W-1:0] p, bit last);
			due   = n;
			point = p;
			seen  = 3'd1;
			if (last) reject_seq(3'd1);
		endfunction

		function void decode_text_byte(bit [7:0] b, bit last);
			bit [2:0] used;
			used = seen + 3'd1;
			if (!b[7]) begin
				if (due != 0) reject_seq(used);
				else finish_char({14'd0, b[6:0]}, 3'd1);
			end else if (b[7:6] == 2'b10) begin
				if (due == 0) begin
					reject_seq(3'd1);
				end else begin
					point = {point[POINT_W-7:0], b[5:0]};
					due   = due - 2'd1;
					seen  = used;
					if (due == 0) finish_char(point, used);
					else if (last) reject_seq(used);
				end
			end else if (due != 0) begin
				reject_seq(used);
			end else if (b[7:3] == 5'b11110) begin
				start_seq(2'd3, {18'd0, b[2:0]}, last);
			end else if (b[7:4] == 4'b1110) begin
				start_seq(2'd2, {17'd0, b[3:0]}, last);
			end else if (b[7:5] == 3'b110) begin
				start_seq(2'd1, {16'd0, b[4:0]}, last);
			end else begin
				reject_seq(3'd1);
			end
		endfunction

		function void note_request(func_t f, bit [KEY_W-1:0] uni, bit [CODE_W-1:0] cc,
				bit [7:0] b, bit last);
			case (f)
				FN_TEXT: decode_text_byte(b, last);
				FN_ADD: begin
					if (fill >= TABLE_DEPTH) begin
						owe(RS_FULL, '0, 3'd0);
					end else begin
						keys[fill]  = uni;
						codes[fill] = cc;
						fill++;
						owe(RS_ADDED, '0, 3'd0);
					end
				end
				FN_CLEAR: begin
					fill = 0;
					owe(RS_CLEARED, '0, 3'd0);
				end
				default: ;
			endcase
		endfunction

		function void match_result(logic [2:0] st, logic [CODE_W-1:0] cc, logic [2:0] used);
			char_result_t want;
			if (owed_results.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, actual status %0d code %0h bytes %0d",
					$time, st, cc, used);
				return;
			end
			want = owed_results.pop_front();
			checked++;
			by_status[int'(want.st)]++;
			if (st !== want.st) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.st, st);
			end
			if (cc !== want.char_code) begin
				errors++;
				$display("%0t: char_code expected %0h actual %0h", $time, want.char_code, cc);
			end
			if (used !== want.used) begin
				errors++;
				$display("%0t: bytes_used expected %0d actual %0d", $time, want.used, used);
			end
		endfunction
	endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the UTF-8 to code table mapper with a short directed sequence and
// then random text mixed with table adds and clears, under random idling on
// both channels, and checks every result against the scoreboard prediction.
// ---------------------------------------------------------------------------
module testbench;

	import u8map_pkg::*;
	import code_map_sb_pkg::*;

	localparam int REQUEST_TARGET = 2000;
	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int DRAIN_CYCLES   = 300;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic [KEY_W-1:0]  entry_unicode;
	logic [CODE_W-1:0] entry_code;
	logic [7:0]        text_byte;
	logic              text_end;
	logic              out_valid;
	logic              out_stall;
	logic [2:0]        status;
	logic [CODE_W-1:0] char_code;
	logic [2:0]        bytes_used;

	code_map_scoreboard board = new();

	// keys the block holds right now, used to aim lookups at real entries
	bit [KEY_W-1:0] mapped_keys[$];
	// quiet stretch: neither side idles while this is set
	bit             calm;
	int unsigned    sent;
	int unsigned    cycles;

	utf8_to_code_table_mapper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.entry_unicode(entry_unicode),
		.entry_code   (entry_code),
		.text_byte    (text_byte),
		.text_end     (text_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.char_code    (char_code),
		.bytes_used   (bytes_used)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles == CYCLE_LIMIT) begin
				$display("Timed out after %0d cycles, %0d results still owed",
					cycles, board.outstanding());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Result side: sample at the edge, so the values seen are the ones the
	// handshake used. Then pick the stall for the next cycle.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				board.match_result(status, char_code, bytes_used);
			out_stall <= !calm && ($urandom_range(0, 99) < 8);
		end
	end

	// Present one request and hold it until the block takes it. An optional
	// idle gap comes first; valid drops only for the gap, never mid-request.
	task automatic send_req(func_t f, bit [KEY_W-1:0] uni, bit [CODE_W-1:0] cc,
			bit [7:0] b, bit last);
		int unsigned gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		entry_unicode <= uni;
		entry_code    <= cc;
		text_byte     <= b;
		text_end      <= last;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		board.note_request(f, uni, cc, b, last);
		sent++;
	endtask

	// Unused payload fields get random values so every bit toggles.
	task automatic send_text(bit [7:0] b, bit last);
		send_req(FN_TEXT, 16'($urandom), 8'($urandom), b, last);
	endtask

	task automatic add_entry(bit [KEY_W-1:0] key, bit [CODE_W-1:0] cc);
		send_req(FN_ADD, key, cc, 8'($urandom), 1'($urandom));
		if (mapped_keys.size() < TABLE_DEPTH) mapped_keys.push_back(key);
	endtask

	task automatic clear_table();
		send_req(FN_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
		mapped_keys.delete();
	endtask

	// Keys lean toward ASCII so duplicates show up; zero is stored now and
	// then and must never match.
	function automatic bit [KEY_W-1:0] pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) return 16'($urandom_range(1, 'h7F));
		if (r < 70) return 16'($urandom_range('h80, 'h7FF));
		if (r < 95) return 16'($urandom);
		return 16'h0000;
	endfunction

	// Mostly aim at keys in the table; the rest spans every encoding length,
	// code points above the key range and zero.
	function automatic bit [POINT_W-1:0] pick_point();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55 && mapped_keys.size() != 0)
			return 21'(mapped_keys[$urandom_range(0, mapped_keys.size() - 1)]);
		if (r < 65) return 21'($urandom_range(1, 'h7F));
		if (r < 75) return 21'($urandom_range('h80, 'h7FF));
		if (r < 88) return 21'($urandom_range('h800, 'hFFFF));
		if (r < 96) return 21'($urandom_range('h10000, 'h10FFFF));
		return 21'd0;
	endfunction

	function automatic int natural_len(bit [POINT_W-1:0] cp);
		if (cp < 'h80) return 1;
		if (cp < 'h800) return 2;
		if (cp < 'h10000) return 3;
		return 4;
	endfunction

	// Encode cp in n bytes (more than needed gives an overlong form) and send
	// the first keep of them; text_end goes on the last byte sent. Now and
	// then a table request lands between two bytes of the character.
	task automatic send_seq(bit [POINT_W-1:0] cp, int n, int keep, bit last_flag);
		bit [7:0] seq[4];
		case (n)
			1: seq[0] = {1'b0, cp[6:0]};
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 3) begin
				if ($urandom_range(0, 3) == 0) clear_table();
				else add_entry(pick_key(), 8'($urandom));
			end
			send_text(seq[i], (i == keep - 1) ? last_flag : 1'b0);
		end
	endtask

	// Fill the table to the top and knock twice on the full door.
	task automatic fill_table();
		repeat (TABLE_DEPTH + 2 - mapped_keys.size()) add_entry(pick_key(), 8'($urandom));
	endtask

	initial begin
		int unsigned      r;
		int               n;
		bit [POINT_W-1:0] cp;
		bit [7:0]         b;
		bit               burst_done;

		burst_done    = 1'b0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		func          <= FN_TEXT;
		entry_unicode <= '0;
		entry_code    <= '0;
		text_byte     <= '0;
		text_end      <= 1'b0;
		calm          <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Lookup into an empty table.
		send_text(8'h41, 1'b0);
		// Duplicate keys: the first entry has code 0 and must still win.
		add_entry(16'h0041, 8'h00);
		add_entry(16'h0041, 8'h55);
		add_entry(16'hFFFF, 8'hFF);
		// Code point zero never maps.
		send_text(8'h00, 1'b0);
		// Add in the middle of a three-byte character; the character survives.
		send_text(8'hE2, 1'b0);
		add_entry(16'h20AC, 8'h80);
		send_text(8'h82, 1'b0);
		send_text(8'hAC, 1'b0);
		// Overlong two-byte 'A' decodes as plain 'A'.
		send_seq(21'h000041, 2, 2, 1'b0);
		// Top of the key range, then the first code point above it.
		send_seq(21'h00FFFF, 3, 3, 1'b0);
		send_seq(21'h010000, 4, 4, 1'b1);
		// Stray continuation and a byte that can never start a sequence.
		send_text(8'h80, 1'b0);
		send_text(8'hF8, 1'b0);
		// ASCII while a continuation is due.
		send_text(8'hC3, 1'b0);
		send_text(8'h41, 1'b0);
		// Text ends inside a character.
		send_seq(21'h0020AC, 3, 2, 1'b1);
		// Clear in the middle of a character, then finish it into the empty table.
		send_text(8'hC3, 1'b0);
		clear_table();
		send_text(8'hA9, 1'b0);

		// Random part: mostly well-formed text with random content, with table
		// traffic, a few fill-ups and a share of broken input.
		while (sent < REQUEST_TARGET) begin
			calm <= (sent >= 800 && sent < 1300);
			if (!burst_done && sent >= 300) begin
				fill_table();
				burst_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				cp = pick_point();
				n  = natural_len(cp);
				if (n < 4 && $urandom_range(0, 19) == 0) n++;
				send_seq(cp, n, n, $urandom_range(0, 9) == 0);
			end else if (r < 75) begin
				add_entry(pick_key(), 8'($urandom));
			end else if (r < 77) begin
				clear_table();
			end else if (r < 78) begin
				if ($urandom_range(0, 3) == 0) fill_table();
				else clear_table();
			end else if (r < 86) begin
				// raw noise byte
				send_text(8'($urandom), 1'($urandom));
			end else if (r < 94) begin
				// truncated character
				n = $urandom_range(2, 4);
				send_seq(pick_point(), n, $urandom_range(1, n - 1), 1'b1);
			end else begin
				// partial character cut short by a byte that is not a continuation
				n = $urandom_range(2, 4);
				send_seq(pick_point(), n, $urandom_range(1, n - 1), 1'b0);
				b = 8'($urandom);
				if (b[7:6] == 2'b10) b[6] = 1'b1;
				send_text(b, 1'($urandom));
			end
		end
		in_valid <= 1'b0;
		calm     <= 1'b0;

		// Drain: wait for every owed result, then hold a while for strays.
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests and %0d results: %0d mapped, %0d unmapped or invalid,",
			sent, board.checked, board.by_status[int'(RS_MAPPED)],
			board.by_status[int'(RS_UNMAPPED)]);
		$display("%0d entries added, %0d adds refused on a full table, %0d clears, %0d errors.",
			board.by_status[int'(RS_ADDED)], board.by_status[int'(RS_FULL)],
			board.by_status[int'(RS_CLEARED)], board.errors);
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/u8map_pkg.sv
hdl/u8map_ram.sv
hdl/u8map_dp.sv
hdl/u8map_ctrl.sv
hdl/utf8_to_code_table_mapper.sv
tb/code_map_sb_pkg.sv
tb/testbench.sv
